>>> src/i2cbc_pkg.sv
// ----------------------------------------------------------------------------
// I2C bus clear package
// Shared types, register indexes and reset values for the bus clear sequencer.
// ----------------------------------------------------------------------------
package i2cbc_pkg;

  localparam int unsigned HALF_W    = 16;
  localparam int unsigned PULSE_W   = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [HALF_W-1:0]  HALF_RESET  = HALF_W'(480);
  localparam logic [PULSE_W-1:0] PULSE_RESET = PULSE_W'(100);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_HALF_PERIOD = cfg_idx_t'(0);
  localparam cfg_idx_t REG_MAX_PULSES  = cfg_idx_t'(1);

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LOW  = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_HOLD = 4'b1000
  } phase_t;

endpackage

>>> src/i2cbc_if.sv
// ----------------------------------------------------------------------------
// I2C bus clear channels
// Valid/ready channels for tick samples, results and register writes.
// ----------------------------------------------------------------------------
interface i2cbc_req_if;
  logic valid;
  logic ready;
  logic start_req;
  logic sda_level;
  logic scl_level;

  modport source (output valid, output start_req, output sda_level, output scl_level,
                  input ready);
  modport sink (input valid, input start_req, input sda_level, input scl_level,
                output ready);
endinterface

interface i2cbc_res_if;
  logic valid;
  logic ready;
  logic scl_drive_low;
  logic pins_taken;
  logic busy_res;
  logic done_res;
  logic outcome;

  modport source (output valid, output scl_drive_low, output pins_taken, output busy_res,
                  output done_res, output outcome, input ready);
  modport sink (input valid, input scl_drive_low, input pins_taken, input busy_res,
                input done_res, input outcome, output ready);
endinterface

interface i2cbc_cfg_if;
  import i2cbc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/i2c_bus_clear_sequencer.sv
// ----------------------------------------------------------------------------
// I2C bus clear sequencer
// Takes one pin sample per transfer and steps the bus clear sequence, sending
// SCL pulses while SDA is held low and returning the pins when done.
// ----------------------------------------------------------------------------
// Result: registered, and offered in the cycle after its sample transfer is accepted.
// Throughput: one sample per cycle when results are taken; the output register
// lets a new sample in while the previous result is taken in the same cycle.
// Reset: synchronous; the sequence returns to idle, counters clear and the
// registers take their reset values (half period 480, pulse limit 100).
module i2c_bus_clear_sequencer (
  input logic clk,
  input logic rst,
  i2cbc_req_if.sink   req,
  i2cbc_res_if.source res,
  i2cbc_cfg_if.sink   cfg
);
  import i2cbc_pkg::*;

  logic [HALF_W-1:0]  half_period_ticks;
  logic [PULSE_W-1:0] max_pulses;
  phase_t             phase, phase_next;
  logic [PULSE_W-1:0] pulse_count, pulse_count_next;
  logic [HALF_W-1:0]  delay_count, delay_count_next;
  logic               done_next, gave_up_next;

  logic [HALF_W-1:0]  eff_half;
  logic [HALF_W-1:0]  delay_inc;
  logic               accept;
  logic               check;
  logic [PULSE_W-1:0] check_pulses;

  logic res_valid;
  logic scl_drive_low, pins_taken, busy_res, done_res, outcome;

  assign cfg.ready = 1'b1;
  assign req.ready = !res_valid || res.ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_RESET;
      max_pulses        <= PULSE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HALF_PERIOD: half_period_ticks <= cfg.data;
        REG_MAX_PULSES:  max_pulses <= cfg.data[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_half  = (half_period_ticks == '0) ? HALF_W'(1) : half_period_ticks;
  assign delay_inc = delay_count + HALF_W'(1);

  always_comb begin
    phase_next       = phase;
    pulse_count_next = pulse_count;
    delay_count_next = delay_count;
    check            = 1'b0;
    check_pulses     = pulse_count;
    done_next        = 1'b0;
    gave_up_next     = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (req.start_req) begin
          check        = 1'b1;
          check_pulses = '0;
          pulse_count_next = '0;
          delay_count_next = '0;
        end
      end
      PH_LOW: begin
        delay_count_next = delay_inc;
        if (delay_inc >= eff_half) begin
          delay_count_next = '0;
          phase_next       = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (req.scl_level) begin
          delay_count_next = '0;
          phase_next       = PH_HOLD;
        end
      end
      PH_HOLD: begin
        delay_count_next = delay_inc;
        if (delay_inc >= eff_half) begin
          delay_count_next = '0;
          check            = 1'b1;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    if (check) begin
      if (req.sda_level) begin
        done_next  = 1'b1;
        phase_next = PH_IDLE;
      end else if (check_pulses >= max_pulses) begin
        done_next    = 1'b1;
        gave_up_next = 1'b1;
        phase_next   = PH_IDLE;
      end else begin
        pulse_count_next = check_pulses + PULSE_W'(1);
        delay_count_next = '0;
        phase_next       = PH_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      pulse_count <= '0;
      delay_count <= '0;
      res_valid   <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      pulse_count <= pulse_count_next;
      delay_count <= delay_count_next;
      res_valid   <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_drive_low <= (phase_next == PH_LOW);
      pins_taken    <= (phase_next != PH_IDLE);
      busy_res      <= (phase_next != PH_IDLE);
      done_res      <= done_next;
      outcome       <= gave_up_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.scl_drive_low = scl_drive_low;
  assign res.pins_taken    = pins_taken;
  assign res.busy_res      = busy_res;
  assign res.done_res      = done_res;
  assign res.outcome       = outcome;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && done_res |-> !busy_res && !pins_taken)
    else $error("Result shows done while still busy.");

  a_drive_needs_pins: assert property (@(posedge clk) disable iff (rst)
    res_valid && scl_drive_low |-> pins_taken && busy_res)
    else $error("SCL driven low without holding the pins.");

  a_outcome_with_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && outcome |-> done_res)
    else $error("Outcome set without done.");

  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && !req.start_req |=> phase == PH_IDLE)
    else $error("Sequence left idle without a start request.");

  a_hold_needs_scl: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_WAIT && !req.scl_level |=> phase == PH_WAIT)
    else $error("Hold entered while SCL still reads low.");

endmodule
